@@ hw/rtl/bfns_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bfns_pkg
// Shared types and constants of the bit map find-next-set unit.
// ============================================================================
package bfns_pkg;

  localparam int OP_W  = 4;
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;
  localparam int ERR_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET        = 4'd0,
    OP_CLEAR      = 4'd1,
    OP_TEST       = 4'd2,
    OP_PUSH       = 4'd3,
    OP_POP        = 4'd4,
    OP_SET_ALL    = 4'd5,
    OP_CLEAR_ALL  = 4'd6,
    OP_FIND_FIRST = 4'd7,
    OP_FIND_NEXT  = 4'd8
  } op_t;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_POP   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep_init;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_sweep;
    logic sweep_end;
  } dp_status_t;

endpackage

@@ hw/rtl/bfns_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bfns_ctrl
// Sequencer: takes an item, runs an operation directly in the exec state
// or as a word sweep, and pulses done when the result is ready.
// ============================================================================
module bfns_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  bfns_pkg::dp_status_t   status,
  output bfns_pkg::ctrl_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);
  import bfns_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.needs_sweep) begin
          cmd.sweep_init = 1'b1;
          state_next     = ST_SWEEP;
        end else begin
          cmd.exec   = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        if (status.sweep_end) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ hw/rtl/bfns_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bfns_dp
// Datapath: word store with per-word valid bits, length and cursor
// registers, single-bit read-modify-write and the word sweep for set all
// and the searches.
// ============================================================================
module bfns_dp #(
  parameter int CAPACITY_BITS = 1024,
  parameter int WORD_BITS     = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfns_pkg::ctrl_cmd_t           cmd,
  output bfns_pkg::dp_status_t          status,
  input  logic [bfns_pkg::OP_W-1:0]     operation,
  input  logic [bfns_pkg::IDX_W-1:0]    bit_index,
  input  logic                          push_value,
  input  logic                          initial_length_wr,
  input  logic [bfns_pkg::LEN_W-1:0]    initial_length,
  output logic                          bit_out,
  output logic                          found,
  output logic [bfns_pkg::LEN_W-1:0]    position,
  output logic [bfns_pkg::LEN_W-1:0]    length_now,
  output logic                          is_empty,
  output logic [bfns_pkg::ERR_W-1:0]    error
);
  import bfns_pkg::*;

  localparam int WL = $clog2(WORD_BITS);
  localparam int NW = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA = (NW > 1) ? $clog2(NW) : 1;
  localparam int LW = $clog2(CAPACITY_BITS + 1);
  localparam int CW = ((LW > LEN_W) ? LW : LEN_W) + 1;
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  logic [WORD_BITS-1:0] store [NW];
  logic [NW-1:0]        wvalid;
  logic [LW-1:0]        length;
  logic [LW-1:0]        cursor;
  op_t                  op_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 pv_q;
  logic [CW-1:0]        scan_start;
  logic [WA-1:0]        wptr;

  logic                 bit_q;
  logic                 found_q;
  logic [LW-1:0]        pos_q;
  logic [ERR_W-1:0]     err_q;

  logic [CW-1:0]        len_ext;
  logic [CW-1:0]        idx_ext;
  logic [CW-1:0]        cap_ext;
  logic                 idx_ok;
  logic [CW-1:0]        start_pos;
  logic [CW-1:0]        tgt_pos;
  logic [WA-1:0]        tgt_word;
  logic [WL-1:0]        tgt_off;
  logic [WA-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_word;

  logic [CW-1:0]        base_ext;
  logic [CW-1:0]        base_plus;
  logic                 last_word;
  logic [WA-1:0]        start_word;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] hits;
  logic                 hit_any;
  logic [WL-1:0]        hit_off;

  logic [CW-1:0]        cfg_ext;
  logic [LW-1:0]        cfg_len;

  logic [LW-1:0]        len_next;
  logic [LW-1:0]        cur_next;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic                 clr_all;
  logic                 res_load;
  logic                 res_bit;
  logic                 res_found;
  logic [LW-1:0]        res_pos;
  logic [ERR_W-1:0]     res_err;

  // operand decode
  assign len_ext   = CW'(length);
  assign idx_ext   = CW'(idx_q);
  assign cap_ext   = CW'(CAPACITY_BITS);
  assign idx_ok    = idx_ext < cap_ext;
  assign start_pos = (op_q == OP_FIND_NEXT) ? idx_ext + CW'(1) : '0;

  always_comb begin
    unique case (op_q)
      OP_PUSH: tgt_pos = CW'(cursor);
      OP_POP:  tgt_pos = CW'(cursor) - CW'(1);
      default: tgt_pos = idx_ext;
    endcase
  end

  assign tgt_word = WA'(tgt_pos >> WL);
  assign tgt_off  = tgt_pos[WL-1:0];
  assign rd_addr  = cmd.step ? wptr : tgt_word;
  assign rd_word  = wvalid[rd_addr] ? store[rd_addr] : '0;

  // sweep window for the current word
  assign base_ext   = CW'({wptr, {WL{1'b0}}});
  assign base_plus  = base_ext + CW'(WORD_BITS);
  assign last_word  = base_plus >= len_ext;
  assign start_word = WA'(scan_start >> WL);
  assign lo_mask    = (wptr == start_word) ? (ONES << scan_start[WL-1:0]) : ONES;
  assign hi_mask    = (base_plus > len_ext) ? ~(ONES << len_ext[WL-1:0]) : ONES;
  assign hits       = rd_word & lo_mask & hi_mask;
  assign hit_any    = |hits;

  always_comb begin
    hit_off = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_off = WL'(i);
      end
    end
  end

  always_comb begin
    status.needs_sweep = ((op_q == OP_SET_ALL) || (op_q == OP_FIND_FIRST) ||
                          (op_q == OP_FIND_NEXT)) && (start_pos < len_ext);
    status.sweep_end   = last_word || ((op_q != OP_SET_ALL) && hit_any);
  end

  // item execution
  always_comb begin
    len_next  = length;
    cur_next  = cursor;
    wr_en     = 1'b0;
    wr_data   = rd_word;
    clr_all   = 1'b0;
    res_bit   = 1'b0;
    res_found = 1'b0;
    res_pos   = '0;
    res_err   = ERR_NONE;
    if (cmd.exec) begin
      unique case (op_q) inside
        OP_SET, OP_CLEAR: begin
          if (!idx_ok) begin
            res_err = ERR_RANGE;
          end else begin
            if (idx_ext >= len_ext) begin
              len_next = LW'(idx_ext + CW'(1));
            end
            wr_en            = 1'b1;
            wr_data[tgt_off] = (op_q == OP_SET);
          end
        end
        OP_TEST: begin
          if (!idx_ok) begin
            res_err = ERR_RANGE;
          end else begin
            res_bit = rd_word[tgt_off];
          end
        end
        OP_PUSH: begin
          if (CW'(cursor) >= cap_ext) begin
            res_err = ERR_RANGE;
          end else begin
            if (cursor >= length) begin
              len_next = cursor + LW'(1);
            end
            wr_en            = 1'b1;
            wr_data[tgt_off] = pv_q;
            cur_next         = cursor + LW'(1);
          end
        end
        OP_POP: begin
          if (cursor == '0) begin
            res_err = ERR_POP;
          end else begin
            wr_en            = 1'b1;
            wr_data[tgt_off] = 1'b0;
            cur_next         = cursor - LW'(1);
          end
        end
        OP_CLEAR_ALL: begin
          clr_all  = 1'b1;
          cur_next = '0;
        end
        OP_FIND_NEXT: begin
          res_pos = length;
        end
        OP_SET_ALL, OP_FIND_FIRST: begin
        end
        default: begin
        end
      endcase
    end else if (cmd.step) begin
      if (op_q == OP_SET_ALL) begin
        wr_en   = 1'b1;
        wr_data = rd_word | hi_mask;
      end else begin
        res_found = hit_any;
        if (hit_any) begin
          res_pos = LW'({wptr, hit_off});
        end else if (op_q == OP_FIND_NEXT) begin
          res_pos = length;
        end
      end
    end
  end

  assign res_load = cmd.finish;

  // construction length, saturated to capacity
  assign cfg_ext = CW'(initial_length);
  assign cfg_len = (cfg_ext > cap_ext) ? LW'(CAPACITY_BITS) : LW'(cfg_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      length <= '0;
      cursor <= '0;
    end else if (initial_length_wr) begin
      wvalid <= '0;
      length <= cfg_len;
      cursor <= cfg_len;
    end else begin
      length <= len_next;
      cursor <= cur_next;
      if (clr_all) begin
        wvalid <= '0;
      end else if (wr_en) begin
        wvalid[rd_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[rd_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op_t'(operation);
      idx_q <= bit_index;
      pv_q  <= push_value;
    end
    if (cmd.sweep_init) begin
      scan_start <= start_pos;
      wptr       <= WA'(start_pos >> WL);
    end else if (cmd.step && !status.sweep_end) begin
      wptr <= wptr + WA'(1);
    end
    if (res_load) begin
      bit_q   <= res_bit;
      found_q <= res_found;
      pos_q   <= res_pos;
      err_q   <= res_err;
    end
  end

  assign bit_out    = bit_q;
  assign found      = found_q;
  assign position   = LEN_W'(pos_q);
  assign length_now = LEN_W'(length);
  assign is_empty   = (length == '0);
  assign error      = err_q;

endmodule

@@ hw/rtl/bitmap_find_next_set_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bitmap_find_next_set_unit
// Bit map with logical length and push cursor, set/clear/test, push/pop,
// set all, clear all, find first and find next set bit.
// ============================================================================
// usage:
//   an item (operation, bit_index, push_value) is taken on a clock edge with
//   start high and busy low. busy stays high until the result is produced.
//   the result fields are valid for exactly one cycle while done is high;
//   the receiver always takes it, there is no back-pressure.
//   set, clear, test, push, pop, clear all, unknown codes and searches or
//   set all on an empty range finish in the exec state after start.
//   set all, find first and find next walk the store one word per cycle
//   starting at the word of the search start, until the last word or,
//   for a search, the first hit; done is registered from the finish.
//   start may be raised again in the cycle done is high.
//   initial_length_wr with initial_length clears the store and loads length
//   and cursor; write it only while the unit is idle.
//   reset (rst, synchronous) empties the store, length and cursor.
// ============================================================================
module bitmap_find_next_set_unit #(
  parameter int CAPACITY_BITS = 1024,
  parameter int WORD_BITS     = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic [bfns_pkg::OP_W-1:0]     operation,
  input  logic [bfns_pkg::IDX_W-1:0]    bit_index,
  input  logic                          push_value,
  input  logic                          initial_length_wr,
  input  logic [bfns_pkg::LEN_W-1:0]    initial_length,
  output logic                          bit_out,
  output logic                          found,
  output logic [bfns_pkg::LEN_W-1:0]    position,
  output logic [bfns_pkg::LEN_W-1:0]    length_now,
  output logic                          is_empty,
  output logic [bfns_pkg::ERR_W-1:0]    error
);
  import bfns_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bfns_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bfns_dp #(
    .CAPACITY_BITS (CAPACITY_BITS),
    .WORD_BITS     (WORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .operation         (operation),
    .bit_index         (bit_index),
    .push_value        (push_value),
    .initial_length_wr (initial_length_wr),
    .initial_length    (initial_length),
    .bit_out           (bit_out),
    .found             (found),
    .position          (position),
    .length_now        (length_now),
    .is_empty          (is_empty),
    .error             (error)
  );

endmodule
